[rtl/mse_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mse_pkg
// Shared widths, codes and types of the matrix square entry block.
// ----------------------------------------------------------------------------
package mse_pkg;

	localparam int DATA_W    = 32;
	localparam int IDX_W     = 6;
	localparam int DIM_W     = 7;
	localparam int TDATA_W   = 48;
	localparam int MAX_DIM_D = 64;

	localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	typedef struct packed {
		logic clear;
		logic valid;
	} mac_ctl_t;

endpackage
`default_nettype wire

[rtl/mse_mac.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mse_mac
// Shared multiply-accumulate unit: registered 32x32 product, 32-bit wrapping
// accumulator.
// ----------------------------------------------------------------------------
module mse_mac (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire mse_pkg::mac_ctl_t                ctl,
	input  wire logic signed [mse_pkg::DATA_W-1:0] a,
	input  wire logic signed [mse_pkg::DATA_W-1:0] b,
	output logic                                  busy,
	output logic signed [mse_pkg::DATA_W-1:0]     acc
);

	logic                              vld_s2;
	logic signed [mse_pkg::DATA_W-1:0] prod_s2;
	logic signed [mse_pkg::DATA_W-1:0] acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= ctl.valid;
		end
	end

	// low word of the product only
	always_ff @(posedge clk) begin
		prod_s2 <= a * b;
		if (ctl.clear) begin
			acc_q <= '0;
		end else if (vld_s2) begin
			acc_q <= acc_q + prod_s2;
		end
	end

	assign busy = vld_s2;
	assign acc  = acc_q;

endmodule
`default_nettype wire

[rtl/matrix_square_entry.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// matrix_square_entry
// Stores a square integer matrix A and returns single entries of A times A.
// ----------------------------------------------------------------------------
// A load item (tuser 0) writes one element of A and gives no
// result. A query item (tuser 1) returns entry (row, col) of A*A, summed with
// 32-bit wraparound over dim_in_use terms (capped at MAX_DIM and at 127). The
// query runs on one shared multiply-accumulate unit fed by a two-read-port
// store, one product per cycle, so the input side is held until the last
// product has been accumulated; a query outside the store, or with
// dim_in_use of zero, issues no products and returns zero. The result sits
// in an output register, so loads are taken while it waits; a query that
// finishes while that register is still full holds the input side until it
// drains. Elements read by a query must have been loaded before.
// ----------------------------------------------------------------------------
module matrix_square_entry #(
	parameter int MAX_DIM = mse_pkg::MAX_DIM_D
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             cfg_we,
	input  wire [mse_pkg::DIM_W-1:0]        cfg_wdata,     // dim_in_use
	input  wire                             s_axis_tvalid,
	output logic                            s_axis_tready,
	input  wire [mse_pkg::TDATA_W-1:0]      s_axis_tdata,  // row, col, value
	input  wire [0:0]                       s_axis_tuser,  // action
	output logic                            m_axis_tvalid,
	input  wire                             m_axis_tready,
	output logic [mse_pkg::TDATA_W-1:0]     m_axis_tdata   // product_value, out_row, out_col
);

	localparam int MEM_DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW        = (MAX_DIM > 1) ? $clog2(MEM_DEPTH) : 1;
	localparam int SAT       = (MAX_DIM > 127) ? 127 : MAX_DIM;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_RUN  = 3'b010,
		S_DONE = 3'b100
	} state_t;

	state_t                               state_q;
	logic [mse_pkg::DIM_W-1:0]            dim_q;
	logic [mse_pkg::DIM_W-1:0]            rem_q;
	logic [mse_pkg::DIM_W-1:0]            n_sat;
	logic [AW-1:0]                        addr_a_q;
	logic [AW-1:0]                        addr_b_q;
	logic [AW-1:0]                        wr_addr;
	logic [mse_pkg::IDX_W-1:0]            row_q;
	logic [mse_pkg::IDX_W-1:0]            col_q;
	logic [mse_pkg::DATA_W-1:0]           mem_q [MEM_DEPTH];
	logic signed [mse_pkg::DATA_W-1:0]    rd_a_s1;
	logic signed [mse_pkg::DATA_W-1:0]    rd_b_s1;
	logic                                 vld_s1;
	logic                                 m_valid_q;
	logic [mse_pkg::TDATA_W-1:0]          m_data_q;

	logic                                 s_action;
	logic [mse_pkg::IDX_W-1:0]            s_row;
	logic [mse_pkg::IDX_W-1:0]            s_col;
	logic [mse_pkg::DATA_W-1:0]           s_value;
	logic                                 s_accept;
	logic                                 in_store;
	logic                                 issue;
	logic                                 drained;
	logic                                 out_free;
	logic                                 out_load;
	mse_pkg::mac_ctl_t                    mac_ctl;
	logic                                 mac_busy;
	logic signed [mse_pkg::DATA_W-1:0]    mac_acc;

	assign s_action = s_axis_tuser[0];
	assign s_row    = s_axis_tdata[5:0];
	assign s_col    = s_axis_tdata[11:6];
	assign s_value  = s_axis_tdata[43:12];

	assign s_axis_tready = (state_q == S_IDLE);
	assign s_accept      = s_axis_tvalid && s_axis_tready;
	assign in_store      = (32'(s_row) < MAX_DIM) && (32'(s_col) < MAX_DIM);
	assign wr_addr       = AW'(s_row) * AW'(MAX_DIM) + AW'(s_col);
	assign n_sat         = (dim_q > mse_pkg::DIM_W'(SAT)) ? mse_pkg::DIM_W'(SAT) : dim_q;

	assign issue    = (state_q == S_RUN) && (rem_q != '0);
	assign drained  = ((state_q == S_RUN) && (rem_q == '0) && !vld_s1 && !mac_busy)
		|| (state_q == S_DONE);
	assign out_free = !m_valid_q || m_axis_tready;
	assign out_load = drained && out_free;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_q <= mse_pkg::DIM_RESET;
		end else if (cfg_we) begin
			dim_q <= cfg_wdata;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rem_q   <= '0;
			vld_s1  <= 1'b0;
		end else begin
			vld_s1 <= issue;
			unique case (state_q)
				S_IDLE: begin
					if (s_accept && (s_action == mse_pkg::ACT_QUERY)) begin
						state_q <= S_RUN;
						rem_q   <= in_store ? n_sat : '0;
					end
				end
				S_RUN: begin
					if (issue) begin
						rem_q <= rem_q - mse_pkg::DIM_W'(1);
					end else if (drained) begin
						state_q <= out_free ? S_IDLE : S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// read addresses walk the row of A and the column of A
	always_ff @(posedge clk) begin
		if (s_accept) begin
			row_q    <= s_row;
			col_q    <= s_col;
			addr_a_q <= AW'(s_row) * AW'(MAX_DIM);
			addr_b_q <= AW'(s_col);
		end else if (issue) begin
			addr_a_q <= addr_a_q + AW'(1);
			addr_b_q <= addr_b_q + AW'(MAX_DIM);
		end
	end

	// matrix store: one write port, two read ports
	always_ff @(posedge clk) begin
		if (s_accept && (s_action == mse_pkg::ACT_LOAD) && in_store) begin
			mem_q[wr_addr] <= s_value;
		end
		rd_a_s1 <= mem_q[addr_a_q];
		rd_b_s1 <= mem_q[addr_b_q];
	end

	assign mac_ctl.clear = s_accept;
	assign mac_ctl.valid = vld_s1;

	mse_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.a      (rd_a_s1),
		.b      (rd_b_s1),
		.busy   (mac_busy),
		.acc    (mac_acc)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_data_q <= {4'd0, col_q, row_q, mac_acc};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	a_pipe_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (state_q == S_RUN))
		else $error("read data in flight outside a query");

	a_load_drained: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!vld_s1 && !mac_busy && !issue))
		else $error("result taken before the accumulator settled");

	a_outside_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(s_accept && (s_action == mse_pkg::ACT_QUERY) && !in_store) |=> (rem_q == '0))
		else $error("query outside the store started a sum");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q <= mse_pkg::DIM_W'(SAT))
		else $error("term count beyond the store size");

endmodule
`default_nettype wire
